// File: sv/isc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP scheduler package
// Shared types, constants and the round-robin pick function.
// ----------------------------------------------------------------------------
package isc_pkg;

   // Field geometry of the request matrix and the match result.
   localparam int MAX_PORTS  = 8;
   localparam int PORT_W     = 3;
   localparam int REQ_W      = 64;
   localparam int MVALID_W   = 8;
   localparam int MOUT_W     = 24;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int ITER_CNT_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PORTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATIONS   = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } isc_state_type;

   typedef struct packed {
      logic load;
      logic iterate;
      logic first;
      logic publish;
   } isc_cmd_type;

   typedef struct packed {
      logic                found;
      logic [PORT_W-1:0]   idx;
   } rr_pick_type;

   // First set bit at or above start, otherwise the first set bit overall.
   function automatic rr_pick_type rr_pick(input logic [MAX_PORTS-1:0] cand,
                                           input logic [PORT_W-1:0]    start);
      logic [MAX_PORTS-1:0] upper;
      logic [MAX_PORTS-1:0] sel;
      rr_pick_type          res;
      upper     = cand & (8'hFF << start);
      sel       = (|upper) ? upper : cand;
      res.found = |cand;
      res.idx   = '0;
      for (int k = MAX_PORTS - 1; k >= 0; k--) begin
         if (sel[k]) begin
            res.idx = PORT_W'(k);
         end
      end
      return res;
   endfunction

   // Advance a port number by one, wrapping at the active port count.
   function automatic logic [PORT_W-1:0] wrap_next(input logic [PORT_W-1:0] v,
                                                   input logic [CFG_W-1:0]  n);
      logic [CFG_W-1:0] nxt;
      nxt = {1'b0, v} + 4'd1;
      return (nxt >= n) ? '0 : nxt[PORT_W-1:0];
   endfunction

   // A pointer left over from a larger port count scans from port zero.
   function automatic logic [PORT_W-1:0] scan_start(input logic [PORT_W-1:0] p,
                                                    input logic [CFG_W-1:0]  n);
      return ({1'b0, p} >= n) ? '0 : p;
   endfunction

endpackage
`default_nettype wire

// File: sv/isc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one cell time's request matrix per beat.
// ----------------------------------------------------------------------------
interface isc_req_if;
   import isc_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] request_matrix;

   modport source (output valid, output request_matrix, input ready);
   modport sink   (input valid, input request_matrix, output ready);

endinterface
`default_nettype wire

// File: sv/isc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Match channel
// Valid/ready channel that carries one matching per beat.
// ----------------------------------------------------------------------------
interface isc_rsp_if;
   import isc_pkg::*;

   logic                valid;
   logic                ready;
   logic [MVALID_W-1:0] match_valid;
   logic [MOUT_W-1:0]   match_outputs;

   modport source (output valid, output match_valid, output match_outputs, input ready);
   modport sink   (input valid, input match_valid, input match_outputs, output ready);

endinterface
`default_nettype wire

// File: sv/isc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP scheduler controller
// Sequences load, iterations and publish; owns the result valid flag.
// ----------------------------------------------------------------------------
module isc_ctrl
   import isc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic             rsp_ready,
   output      logic             rsp_valid,
   input  wire logic [CFG_W-1:0] iter_limit,
   output      isc_cmd_type      cmd
);

   isc_state_type         state_ff, state_in;
   logic [ITER_CNT_W-1:0] iter_cnt_ff, iter_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  last_iter;
   logic                  out_free;

   assign last_iter = ({1'b0, iter_cnt_ff} == (iter_limit - 4'd1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_iter) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.iterate = 1'b1;
            cmd.first   = (iter_cnt_ff == '0);
            cmd.publish = last_iter && out_free;
         end
         ST_HOLD: begin
            cmd.publish = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      iter_cnt_in = iter_cnt_ff;
      if (cmd.load) begin
         iter_cnt_in = '0;
      end else if (cmd.iterate) begin
         iter_cnt_in = iter_cnt_ff + 1'b1;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_cnt_ff  <= iter_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: sv/isc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP scheduler datapath
// Match state, round-robin pointers, one grant/accept iteration per cycle.
// ----------------------------------------------------------------------------
module isc_datapath
   import isc_pkg::*;
#(
   parameter int PORTS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire isc_cmd_type         cmd,
   input  wire logic [CFG_W-1:0]    port_count,
   input  wire logic [REQ_W-1:0]    request_matrix,
   output      logic [MVALID_W-1:0] match_valid,
   output      logic [MOUT_W-1:0]   match_outputs
);

   logic [REQ_W-1:0]     req_ff;
   logic [MAX_PORTS-1:0] in_m_ff, in_m_in;
   logic [MAX_PORTS-1:0] out_m_ff, out_m_in;
   logic [PORT_W-1:0]    match_out_ff [MAX_PORTS];
   logic [PORT_W-1:0]    match_out_in [MAX_PORTS];
   logic [PORT_W-1:0]    grant_ptr_ff [PORTS];
   logic [PORT_W-1:0]    grant_ptr_in [PORTS];
   logic [PORT_W-1:0]    accept_ptr_ff [PORTS];
   logic [PORT_W-1:0]    accept_ptr_in [PORTS];
   logic [MVALID_W-1:0]  match_valid_ff;
   logic [MOUT_W-1:0]    match_outputs_ff, packed_in;

   rr_pick_type          grant_pick  [MAX_PORTS];
   rr_pick_type          accept_pick [MAX_PORTS];
   logic [MAX_PORTS-1:0] grant_cand  [MAX_PORTS];
   logic [MAX_PORTS-1:0] accept_cand [MAX_PORTS];
   logic [MAX_PORTS-1:0] out_taken;

   // Grant phase: each free output picks a free requesting input.
   always_comb begin
      for (int o = 0; o < MAX_PORTS; o++) begin
         grant_cand[o] = '0;
         for (int i = 0; i < MAX_PORTS; i++) begin
            grant_cand[o][i] = (i < PORTS) && (o < PORTS) &&
                               (CFG_W'(i) < port_count) && (CFG_W'(o) < port_count) &&
                               !in_m_ff[i] && !out_m_ff[o] && req_ff[i*8 + o];
         end
         if (o < PORTS) begin
            grant_pick[o] = rr_pick(grant_cand[o],
                                    scan_start(grant_ptr_ff[o], port_count));
         end else begin
            grant_pick[o] = '0;
         end
      end
   end

   // Accept phase: each free input picks one output that granted it.
   always_comb begin
      for (int i = 0; i < MAX_PORTS; i++) begin
         accept_cand[i] = '0;
         for (int o = 0; o < MAX_PORTS; o++) begin
            accept_cand[i][o] = grant_pick[o].found &&
                                (grant_pick[o].idx == PORT_W'(i));
         end
         if (i < PORTS) begin
            accept_pick[i] = rr_pick(accept_cand[i],
                                     scan_start(accept_ptr_ff[i], port_count));
         end else begin
            accept_pick[i] = '0;
         end
      end
      for (int o = 0; o < MAX_PORTS; o++) begin
         out_taken[o] = grant_pick[o].found &&
                        accept_pick[grant_pick[o].idx].found &&
                        (accept_pick[grant_pick[o].idx].idx == PORT_W'(o));
      end
   end

   always_comb begin
      in_m_in  = in_m_ff;
      out_m_in = out_m_ff;
      for (int i = 0; i < MAX_PORTS; i++) begin
         match_out_in[i] = match_out_ff[i];
      end
      for (int p = 0; p < PORTS; p++) begin
         grant_ptr_in[p]  = grant_ptr_ff[p];
         accept_ptr_in[p] = accept_ptr_ff[p];
      end
      if (cmd.iterate) begin
         for (int i = 0; i < MAX_PORTS; i++) begin
            if (accept_pick[i].found) begin
               in_m_in[i]      = 1'b1;
               match_out_in[i] = accept_pick[i].idx;
            end
         end
         out_m_in = out_m_ff | out_taken;
         if (cmd.first) begin
            // Pointers only move for matches made in the first iteration.
            for (int p = 0; p < PORTS; p++) begin
               if (accept_pick[p].found) begin
                  accept_ptr_in[p] = wrap_next(accept_pick[p].idx, port_count);
               end
               if (out_taken[p]) begin
                  grant_ptr_in[p] = wrap_next(grant_pick[p].idx, port_count);
               end
            end
         end
      end
      for (int i = 0; i < MAX_PORTS; i++) begin
         packed_in[i*PORT_W +: PORT_W] = in_m_in[i] ? match_out_in[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PORTS; p++) begin
            grant_ptr_ff[p]  <= '0;
            accept_ptr_ff[p] <= '0;
         end
      end else begin
         for (int p = 0; p < PORTS; p++) begin
            grant_ptr_ff[p]  <= grant_ptr_in[p];
            accept_ptr_ff[p] <= accept_ptr_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= request_matrix;
         in_m_ff  <= '0;
         out_m_ff <= '0;
         for (int i = 0; i < MAX_PORTS; i++) begin
            match_out_ff[i] <= '0;
         end
      end else begin
         in_m_ff  <= in_m_in;
         out_m_ff <= out_m_in;
         for (int i = 0; i < MAX_PORTS; i++) begin
            match_out_ff[i] <= match_out_in[i];
         end
      end
      if (cmd.publish) begin
         match_valid_ff   <= in_m_in;
         match_outputs_ff <= packed_in;
      end
   end

   assign match_valid   = match_valid_ff;
   assign match_outputs = match_outputs_ff;

endmodule
`default_nettype wire

// File: sv/islip_crossbar_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP crossbar scheduler core
// Computes one input/output matching per cell time with round-robin pointers.
// ----------------------------------------------------------------------------
// Each request beat carries one cell time's request matrix (bit input*8+output
// set when that input holds a cell for that output). The core runs the
// configured number of request-grant-accept iterations, one iteration per
// clock cycle in the datapath. A beat is accepted, then the iterations run;
// the last iteration writes the result register, or, while the previous
// matching still waits unaccepted, the core holds and writes it once free.
// The reset setting is four iterations. The core works on one beat at a
// time; a finished matching waits in the output register while the next
// request beat is taken. Pointers move only for matches made in the first
// iteration, and wrap at active_ports. Configuration (active_ports at index
// CSR_ACTIVE_PORTS, iterations at CSR_ITERATIONS) must be written only while
// the core is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module islip_crossbar_scheduler_core
   import isc_pkg::*;
#(
   parameter int PORTS          = 8,
   parameter int MAX_ITERATIONS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   isc_req_if.sink                   req_chan,
   isc_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data
);

   // Configuration registers, held as written; clamping happens on use.
   logic [CFG_W-1:0] active_ports_ff;
   logic [CFG_W-1:0] iterations_ff;
   logic [CFG_W-1:0] port_count;
   logic [CFG_W-1:0] iter_limit;
   isc_cmd_type      cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ports_ff <= 4'd8;
         iterations_ff   <= 4'd4;
      end else if (csr_write_en) begin
         // Writes to an index beyond the register list are dropped.
         unique case (csr_index)
            CSR_ACTIVE_PORTS: active_ports_ff <= csr_write_data;
            CSR_ITERATIONS:   iterations_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Out-of-range settings are clamped to the nearest legal value.
   always_comb begin
      if (active_ports_ff < 4'd2) begin
         port_count = 4'd2;
      end else if (active_ports_ff > CFG_W'(PORTS)) begin
         port_count = CFG_W'(PORTS);
      end else begin
         port_count = active_ports_ff;
      end
      if (iterations_ff == '0) begin
         iter_limit = 4'd1;
      end else if (iterations_ff > CFG_W'(MAX_ITERATIONS)) begin
         iter_limit = CFG_W'(MAX_ITERATIONS);
      end else begin
         iter_limit = iterations_ff;
      end
   end

   isc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .iter_limit (iter_limit),
      .cmd        (cmd)
   );

   isc_datapath #(
      .PORTS (PORTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .port_count     (port_count),
      .request_matrix (req_chan.request_matrix),
      .match_valid    (rsp_chan.match_valid),
      .match_outputs  (rsp_chan.match_outputs)
   );

endmodule
`default_nettype wire

// File: sv/isc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP scheduler port checker
// Checks handshake and matching properties seen at the core's ports.
// ----------------------------------------------------------------------------
module isc_checker
   import isc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [MVALID_W-1:0] match_valid,
   input wire logic [MOUT_W-1:0]   match_outputs
);

   logic output_conflict;

   // Two matched inputs that name the same output break the matching.
   always_comb begin
      output_conflict = 1'b0;
      for (int a = 0; a < MAX_PORTS; a++) begin
         for (int b = a + 1; b < MAX_PORTS; b++) begin
            if (match_valid[a] && match_valid[b] &&
                match_outputs[a*PORT_W +: PORT_W] == match_outputs[b*PORT_W +: PORT_W]) begin
               output_conflict = 1'b1;
            end
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_valid) && $stable(match_outputs))
      else $error("match beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("match beat valid right after reset");

   a_one_to_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !output_conflict)
      else $error("two inputs matched to the same output");

   for (genvar g = 0; g < MAX_PORTS; g++) begin : g_unmatched
      a_unmatched_zero: assert property (@(posedge clock) disable iff (reset)
         rsp_valid && !match_valid[g] |-> match_outputs[g*PORT_W +: PORT_W] == '0)
         else $error("unmatched input carries an output number");
   end

endmodule

bind islip_crossbar_scheduler_core isc_checker u_isc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .match_valid   (rsp_chan.match_valid),
   .match_outputs (rsp_chan.match_outputs)
);
`default_nettype wire
